// File: hw/rtl/sctok_pkg.sv
// Shared types and constants for the shell command line tokenizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package sctok_pkg;

  // result queue sizing
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = 2;

  typedef enum logic [2:0] {
    MODE_NAME   = 3'd0,
    MODE_ARG    = 3'd1,
    MODE_IN     = 3'd2,
    MODE_OUT    = 3'd3,
    MODE_APPEND = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    EV_BYTE  = 3'd0,
    EV_END   = 3'd1,
    EV_PIPE  = 3'd2,
    EV_INSTR = 3'd3,
    EV_EMPTY = 3'd4,
    EV_ERROR = 3'd5
  } event_e;

  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_VT   = 8'h0B;
  localparam logic [7:0] CH_FF   = 8'h0C;
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_PIPE = 8'h7C;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;

  typedef struct packed {
    logic       last;
    logic [7:0] ch;
    logic [2:0] role;
    event_e     ev;
  } result_t;

  // results produced by one byte, in order; n is 0..2
  typedef struct packed {
    logic [1:0]       n;
    result_t [1:0]    res;
  } push_t;

endpackage

`default_nettype wire

// File: hw/rtl/shell_command_line_tokenizer_unit.sv
// Shell command line tokenizer, top level. Depends on sctok_pkg, sctok_step, sctok_outq.
// Throughput: one byte per cycle while the four-entry result queue has room for two more
// results; a byte with two results is handed out one word at a time by the single-word
// output port draining that queue.
// Reset: rst_ni async active low; clears the tokenizer state, input and queue valids.
`default_nettype none

module shell_command_line_tokenizer_unit
  import sctok_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [2:0] event_res, [5:3] role, [13:6] char_value
  output logic             m_axis_tlast_o    // last result of this input word
);

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       room, fire;
  logic [2:0] level;
  push_t      push;
  result_t    head;

  // room for two more results without looking at the output handshake
  assign room            = level <= 3'(OQ_DEPTH - 2);
  assign fire            = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) in_byte_q <= s_axis_tdata_i;
  end

  // decision logic plus tokenizer state
  sctok_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .push_o (push)
  );

  // result queue in front of the output port
  sctok_outq u_outq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (fire),
    .push_i    (push),
    .pop_i     (m_axis_tready_i),
    .head_o    (head),
    .valid_o   (m_axis_tvalid_o),
    .level_o   (level)
  );

  assign m_axis_tdata_o = {2'b00, head.ch, head.role, head.ev};
  assign m_axis_tlast_o = head.last;

  // checks
  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= 3'(OQ_DEPTH))
    else $error("result queue overflow");

  a_two_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && push.n == 2'd2 |-> !push.res[0].last && push.res[1].last)
    else $error("last flag misplaced on a two-result word");

  a_one_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && push.n == 2'd1 |-> push.res[0].last)
    else $error("single result lacks last flag");

  a_push_visible: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && push.n != 2'd0 |=> m_axis_tvalid_o)
    else $error("pushed result not presented");

endmodule

`default_nettype wire

// File: hw/rtl/sctok_step.sv
// Tokenizer state register and the per-byte decision logic.
// Depends on sctok_pkg.
`default_nettype none

module sctok_step
  import sctok_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] byte_i,
  output push_t           push_o
);

  typedef struct packed {
    mode_e mode;
    logic  token_open;
    logic  name_seen;
    logic  piped;
    logic  pending_gt;
    logic  after_semi;
    logic  in_comment;
    logic  discarding;
  } state_t;

  state_t st_q, st_d;

  logic is_gt, is_op, is_semi, is_nl, is_eol, is_term, is_blank, is_rsvd;
  logic go, fault;
  logic [1:0] n;
  result_t [1:0] res;

  assign is_gt    = byte_i == CH_GT;
  assign is_op    = is_gt || byte_i == CH_LT || byte_i == CH_PIPE;
  assign is_semi  = byte_i == CH_SEMI;
  assign is_nl    = byte_i == CH_NL;
  assign is_eol   = is_nl || byte_i == CH_NUL;
  assign is_term  = is_eol || is_semi || byte_i == CH_HASH;
  assign is_blank = byte_i == CH_SP || byte_i == CH_TAB || byte_i == CH_NL
                 || byte_i == CH_VT || byte_i == CH_FF || byte_i == CH_CR;

  always_comb begin
    case (byte_i)
      8'h22, 8'h27, 8'h5C, 8'h24, 8'h7B, 8'h7D, 8'h28, 8'h29,
      8'h5B, 8'h5D, 8'h2A, 8'h3F, 8'h7E, 8'h26, 8'h3D, 8'h21: is_rsvd = 1'b1;
      default: is_rsvd = 1'b0;
    endcase
  end

  always_comb begin
    st_d  = st_q;
    n     = 2'd0;
    res   = '0;
    go    = 1'b0;
    fault = 1'b0;

    // lookahead and discard states come first
    if (st_q.discarding || st_q.in_comment) begin
      if (is_eol) begin
        st_d.discarding = 1'b0;
        st_d.in_comment = 1'b0;
        go = 1'b1;
      end
    end else if (st_q.after_semi) begin
      if (!(is_blank && !is_nl)) begin
        st_d.after_semi = 1'b0;
        if (is_semi) fault = 1'b1;
        else go = 1'b1;
      end
    end else if (st_q.pending_gt) begin
      st_d.pending_gt = 1'b0;
      if (is_gt) st_d.mode = MODE_APPEND;
      else go = 1'b1;
    end else begin
      go = 1'b1;
    end

    if (go) begin
      // separators close an open token
      if ((is_op || is_term || is_blank) && st_d.token_open) begin
        res[n[0]].ev   = EV_END;
        res[n[0]].role = st_d.mode;
        res[n[0]].ch   = byte_i;
        n = n + 2'd1;
        st_d.token_open = 1'b0;
        if (st_d.mode == MODE_NAME) st_d.name_seen = 1'b1;
        st_d.mode = st_d.name_seen ? MODE_ARG : MODE_NAME;
      end

      if (is_op) begin
        if (st_d.mode >= MODE_IN) begin
          fault = 1'b1;
        end else if (is_gt) begin
          st_d.mode       = MODE_OUT;
          st_d.pending_gt = 1'b1;
        end else if (byte_i == CH_LT) begin
          st_d.mode = MODE_IN;
        end else if (!st_d.name_seen) begin
          fault = 1'b1;
        end else begin
          res[n[0]].ev = EV_PIPE;
          res[n[0]].ch = byte_i;
          n = n + 2'd1;
          st_d.piped     = 1'b1;
          st_d.name_seen = 1'b0;
          st_d.mode      = MODE_NAME;
        end
      end else if (is_term) begin
        if (!st_d.name_seen && st_d.piped) begin
          fault = 1'b1;
        end else begin
          res[n[0]].ev = st_d.name_seen ? EV_INSTR : EV_EMPTY;
          res[n[0]].ch = byte_i;
          n = n + 2'd1;
          st_d.mode       = MODE_NAME;
          st_d.token_open = 1'b0;
          st_d.name_seen  = 1'b0;
          st_d.piped      = 1'b0;
          st_d.pending_gt = 1'b0;
          st_d.after_semi = 1'b0;
          if (byte_i == CH_HASH) st_d.in_comment = 1'b1;
          else if (is_semi) st_d.after_semi = 1'b1;
        end
      end else if (is_blank) begin
        // separator only
      end else if (is_rsvd) begin
        fault = 1'b1;
      end else begin
        res[n[0]].ev   = EV_BYTE;
        res[n[0]].role = st_d.mode;
        res[n[0]].ch   = byte_i;
        n = n + 2'd1;
        st_d.token_open = 1'b1;
      end
    end

    // a fault is always the final result of a byte
    if (fault) begin
      res[n[0]].ev   = EV_ERROR;
      res[n[0]].role = '0;
      res[n[0]].ch   = byte_i;
      n = n + 2'd1;
      st_d.mode       = MODE_NAME;
      st_d.token_open = 1'b0;
      st_d.name_seen  = 1'b0;
      st_d.piped      = 1'b0;
      st_d.pending_gt = 1'b0;
      st_d.after_semi = 1'b0;
      st_d.in_comment = 1'b0;
      st_d.discarding = !is_eol;
    end

    if (n == 2'd1) res[0].last = 1'b1;
    else if (n == 2'd2) res[1].last = 1'b1;
  end

  assign push_o.n   = n;
  assign push_o.res = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (fire_i) begin
      st_q <= st_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/sctok_outq.sv
// Small result queue: takes up to two results a cycle, hands out one.
// Depends on sctok_pkg.
`default_nettype none

module sctok_outq
  import sctok_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_en_i,
  input  push_t       push_i,
  input  wire logic   pop_i,
  output result_t     head_o,
  output logic        valid_o,
  output logic [2:0]  level_o
);

  result_t mem_q [OQ_DEPTH];
  logic [OQ_AW-1:0] rd_q, wr_q, wr_nx;
  logic [2:0] cnt_q;
  logic [1:0] pn;
  logic       pop;

  assign pn      = push_en_i ? push_i.n : 2'd0;
  assign valid_o = cnt_q != 3'd0;
  assign pop     = valid_o && pop_i;
  assign head_o  = mem_q[rd_q];
  assign level_o = cnt_q;
  assign wr_nx   = wr_q + OQ_AW'(1);

  always_ff @(posedge clk_i) begin
    if (pn != 2'd0) mem_q[wr_q] <= push_i.res[0];
    if (pn == 2'd2) mem_q[wr_nx] <= push_i.res[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q  <= '0;
      wr_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + OQ_AW'(pn);
      if (pop) rd_q <= rd_q + OQ_AW'(1);
      cnt_q <= cnt_q + {1'b0, pn} - {2'b0, pop};
    end
  end

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking bench for shell_command_line_tokenizer_unit: a byte stream goes in on s_axis
// and the result words are checked against a tokenizer predictor held in this file.
// Depends on sctok_pkg and the RTL of the block.
module testbench;
  import sctok_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one expected result word
  typedef struct packed {
    event_e     ev;
    logic [2:0] role;
    logic [7:0] ch;
    logic       last;
  } tok_word_t;

  // Reserved characters: " ' \ $ { } ( ) [ ] * ? ~ & = !
  localparam logic [7:0] RESERVED_CH [16] = '{
    8'h22, 8'h27, 8'h5C, 8'h24, 8'h7B, 8'h7D, 8'h28, 8'h29,
    8'h5B, 8'h5D, 8'h2A, 8'h3F, 8'h7E, 8'h26, 8'h3D, 8'h21
  };

  localparam int RANDOM_BYTES = 1100;
  localparam int HOLD_AT      = 300;   // accepted bytes before the long output stall
  localparam int HOLD_LEN     = 150;   // cycles of that stall
  localparam int CALM_FROM    = 600;   // cycle window with no random idling at all
  localparam int CALM_TO      = 1000;
  localparam int STUCK_LIMIT  = 2000;  // cycles without any handshake before giving up
  localparam int DRAIN_CYCLES = 20;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i = CH_NUL;   // [7:0] char_code
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;            // [2:0] event_res, [5:3] role, [13:6] char_value
  logic        m_axis_tlast_o;

  always #2 clk_i = ~clk_i;

  shell_command_line_tokenizer_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // ---------------------------------------------------------------------------
  // Tokenizer predictor: its own copy of the parse state.
  // ---------------------------------------------------------------------------
  mode_e     tk_mode;
  logic      tk_open;       // token bytes have been emitted, no end yet
  logic      tk_named;      // command name seen in this pipeline stage
  logic      tk_piped;      // a pipe has been seen in this instruction
  logic      tk_gt;         // '>' seen, waiting to know if it is '>>'
  logic      tk_semi;       // ';' seen, watching for ';;'
  logic      tk_comment;
  logic      tk_skip;       // dropping bytes after a syntax error

  tok_word_t step_words[$];       // results of the byte being predicted
  tok_word_t expected_words_q[$]; // results not yet seen on m_axis
  logic [7:0] console_q[$];       // bytes still to be offered on s_axis

  int fail_cnt = 0;
  int bytes_in = 0;
  int words_out = 0;
  int total_bytes = 0;
  int ev_cnt [6];
  int cyc = 0;
  int stuck_cyc = 0;
  logic in_taken = 1'b0;          // s_axis word accepted at the last rising edge

  function automatic bit is_blank(logic [7:0] c);
    case (c)
      CH_SP, CH_TAB, CH_NL, CH_VT, CH_FF, CH_CR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic bit is_reserved(logic [7:0] c);
    foreach (RESERVED_CH[i])
      if (RESERVED_CH[i] == c) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void emit_word(event_e ev, logic [2:0] role, logic [7:0] c);
    tok_word_t w;
    w.ev   = ev;
    w.role = role;
    w.ch   = c;
    w.last = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void clear_instruction();
    tk_mode  = MODE_NAME;
    tk_open  = 1'b0;
    tk_named = 1'b0;
    tk_piped = 1'b0;
    tk_gt    = 1'b0;
    tk_semi  = 1'b0;
  endfunction

  // separator while a token is open: token end, then name or argument mode
  function automatic void close_token(logic [7:0] c);
    if (!tk_open) return;
    emit_word(EV_END, tk_mode, c);
    tk_open = 1'b0;
    if (tk_mode == MODE_NAME) tk_named = 1'b1;
    if (tk_named) tk_mode = MODE_ARG;
    else tk_mode = MODE_NAME;
  endfunction

  // an erring newline or NUL ends the line itself, so nothing gets dropped
  function automatic void raise_fault(logic [7:0] c);
    emit_word(EV_ERROR, MODE_NAME, c);
    clear_instruction();
    tk_comment = 1'b0;
    tk_skip    = !(c == CH_NL || c == CH_NUL);
  endfunction

  function automatic void parse_byte(logic [7:0] c);
    if (c == CH_GT || c == CH_LT || c == CH_PIPE) begin
      close_token(c);
      if (tk_mode >= MODE_IN) begin
        // operator where a redirect target belongs
        raise_fault(c);
      end else if (c == CH_GT) begin
        tk_mode = MODE_OUT;
        tk_gt   = 1'b1;
      end else if (c == CH_LT) begin
        tk_mode = MODE_IN;
      end else if (!tk_named) begin
        raise_fault(c);
      end else begin
        emit_word(EV_PIPE, MODE_NAME, c);
        tk_piped = 1'b1;
        tk_named = 1'b0;
        tk_mode  = MODE_NAME;
      end
    end else if (c == CH_HASH || c == CH_SEMI || c == CH_NL || c == CH_NUL) begin
      close_token(c);
      if (!tk_named && tk_piped) begin
        raise_fault(c);   // pipe left dangling
      end else begin
        // a pending redirect with no target is simply dropped here
        if (tk_named) emit_word(EV_INSTR, MODE_NAME, c);
        else emit_word(EV_EMPTY, MODE_NAME, c);
        clear_instruction();
        tk_comment = (c == CH_HASH);
        tk_semi    = (c == CH_SEMI);
      end
    end else if (is_blank(c)) begin
      close_token(c);
    end else if (is_reserved(c)) begin
      raise_fault(c);     // no token end ahead of it
    end else begin
      emit_word(EV_BYTE, tk_mode, c);
      tk_open = 1'b1;
    end
  endfunction

  // one accepted byte -> its result words appended to expected_words_q
  function automatic void tokenize_byte(logic [7:0] c);
    step_words.delete();
    if (tk_skip || tk_comment) begin
      if (c == CH_NL || c == CH_NUL) begin
        tk_skip    = 1'b0;
        tk_comment = 1'b0;
        parse_byte(c);
      end
    end else if (tk_semi) begin
      // blanks other than newline keep the ';;' lookahead alive
      if (!(is_blank(c) && c != CH_NL)) begin
        tk_semi = 1'b0;
        if (c == CH_SEMI) raise_fault(c);
        else parse_byte(c);
      end
    end else if (tk_gt) begin
      tk_gt = 1'b0;
      if (c == CH_GT) tk_mode = MODE_APPEND;
      else parse_byte(c);
    end else begin
      parse_byte(c);
    end
    if (step_words.size() != 0) step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[i]) expected_words_q.push_back(step_words[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus: command lines with random content, some broken, plus raw noise.
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] word_char();
    case ($urandom_range(0, 9))
      0: return 8'($urandom_range(128, 255));   // non-ASCII bytes are ordinary
      1: return 8'($urandom_range(48, 57));
      2: return 8'($urandom_range(65, 90));
      3: return 8'h2D + 8'($urandom_range(0, 2)); // - . /
      default: return 8'($urandom_range(97, 122));
    endcase
  endfunction

  function automatic void put_word();
    repeat ($urandom_range(1, 6)) console_q.push_back(word_char());
  endfunction

  function automatic void put_gap(int min_n);
    repeat ($urandom_range(min_n, 2)) begin
      case ($urandom_range(0, 7))
        0: console_q.push_back(CH_TAB);
        1: console_q.push_back(CH_VT);
        2: console_q.push_back(CH_FF);
        3: console_q.push_back(CH_CR);
        default: console_q.push_back(CH_SP);
      endcase
    end
  endfunction

  function automatic void put_line();
    int n_cmd;
    n_cmd = $urandom_range(1, 3);
    for (int k = 0; k < n_cmd; k++) begin
      if (k != 0) begin
        put_gap(0);
        console_q.push_back(CH_PIPE);
        put_gap(0);
      end
      put_word();
      repeat ($urandom_range(0, 3)) begin
        put_gap(1);
        put_word();
      end
      if ($urandom_range(0, 2) == 0) begin
        put_gap(0);
        case ($urandom_range(0, 2))
          0: console_q.push_back(CH_LT);
          1: console_q.push_back(CH_GT);
          default: begin
            console_q.push_back(CH_GT);
            console_q.push_back(CH_GT);
          end
        endcase
        put_gap(0);
        put_word();
      end
    end
    // about one line in eight gets a flaw before its end
    if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 5))
        0: console_q.push_back(RESERVED_CH[$urandom_range(0, 15)]);
        1: console_q.push_back(CH_PIPE);
        2: begin
          console_q.push_back(CH_GT);
          console_q.push_back(CH_LT);
        end
        3: begin
          console_q.push_back(CH_SEMI);
          put_gap(0);
          console_q.push_back(CH_SEMI);
        end
        4: begin
          console_q.push_back(CH_PIPE);
          console_q.push_back(CH_PIPE);
        end
        default: console_q.push_back(CH_GT);
      endcase
    end
    case ($urandom_range(0, 4))
      0: begin
        console_q.push_back(CH_SEMI);
        put_gap(0);
      end
      1: begin
        console_q.push_back(CH_HASH);
        put_word();
        console_q.push_back(CH_NL);
      end
      2: console_q.push_back(CH_NUL);
      default: console_q.push_back(CH_NL);
    endcase
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_cnt++;
    end
  endfunction

  // Quiet window: no random idling on either side inside it.
  wire calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  // ---------------------------------------------------------------------------
  // Driver: offers console bytes at the falling edge; a word stays up until taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic       nxt_valid;
    logic [7:0] nxt_data;
    nxt_valid = s_axis_tvalid_i;
    nxt_data  = s_axis_tdata_i;
    if (rst_ni && (!s_axis_tvalid_i || in_taken)) begin
      nxt_valid = 1'b0;
      if (console_q.size() != 0 && (calm || $urandom_range(0, 99) >= 6)) begin
        nxt_valid = 1'b1;
        nxt_data  = console_q.pop_front();
      end
    end
    s_axis_tvalid_i <= nxt_valid;
    s_axis_tdata_i  <= nxt_data;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random back-pressure plus one long hold so the result queue fills
  // and the block has to stall its input.
  // ---------------------------------------------------------------------------
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else if (!hold_done && bytes_in >= HOLD_AT) begin
      hold_left       <= HOLD_LEN;
      hold_done       <= 1'b1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= rst_ni && (calm || $urandom_range(0, 99) >= 6);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard: both handshakes sampled at the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    tok_word_t want;
    logic      in_hs;
    logic      out_hs;
    in_hs  = rst_ni && s_axis_tvalid_i && s_axis_tready_o;
    out_hs = rst_ni && m_axis_tvalid_o && m_axis_tready_i;
    cyc      <= cyc + 1;
    in_taken <= in_hs;
    if (in_hs) begin
      tokenize_byte(s_axis_tdata_i);
      bytes_in <= bytes_in + 1;
    end
    if (out_hs) begin
      words_out <= words_out + 1;
      if (expected_words_q.size() == 0) begin
        $error("result word with nothing expected: data %h last %b",
               m_axis_tdata_o, m_axis_tlast_o);
        fail_cnt++;
      end else begin
        want = expected_words_q.pop_front();
        ev_cnt[want.ev]++;
        check_field("event_res", want.ev, m_axis_tdata_o[2:0]);
        check_field("role", want.role, m_axis_tdata_o[5:3]);
        check_field("char_value", want.ch, m_axis_tdata_o[13:6]);
        check_field("last", want.last, m_axis_tlast_o);
        check_field("tdata padding", 0, m_axis_tdata_o[15:14]);
      end
    end
    // watchdog: any long stretch with no word moving on either side is a hang
    if (rst_ni) begin
      if (in_hs || out_hs) begin
        stuck_cyc <= 0;
      end else if (stuck_cyc >= STUCK_LIMIT) begin
        $error("no handshake for %0d cycles, %0d words still expected",
               stuck_cyc, expected_words_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        stuck_cyc <= stuck_cyc + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: load stimulus, reset, wait for everything to drain, report.
  // ---------------------------------------------------------------------------
  initial begin
    foreach (ev_cnt[i]) ev_cnt[i] = 0;
    tk_comment = 1'b0;
    tk_skip    = 1'b0;
    clear_instruction();

    // Directed line: extremes and each special case of the tokenizer.
    console_q = {
      8'h61, 8'hFF, CH_SP,            // name with a non-ASCII byte, token end
      CH_GT, CH_GT, 8'h66, CH_PIPE,   // append target, then a pipe
      CH_NL,                          // dangling pipe, error on the newline itself
      CH_PIPE, 8'h7A, CH_NUL,         // pipe without a command, dropped byte, NUL
      8'h63, CH_LT, CH_GT, CH_NL,     // operator where a redirect target belongs
      8'h63, CH_GT, CH_SEMI,          // redirect left without target is dropped
      CH_TAB, CH_SEMI, CH_NL,         // ';' blank ';' is an error
      CH_HASH, 8'h21, CH_NL,          // comment hides a reserved byte
      8'h24, CH_NUL, CH_SP,           // reserved byte, blank with no token open
      8'h3F, CH_NL                    // '?' is reserved as well
    };
    while (console_q.size() < 30 + RANDOM_BYTES) begin
      if ($urandom_range(0, 99) < 12) begin
        repeat ($urandom_range(1, 4)) console_q.push_back(8'($urandom_range(0, 255)));
      end else begin
        put_line();
      end
    end
    total_bytes = console_q.size();

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (bytes_in != total_bytes || expected_words_q.size() != 0) @(negedge clk_i);
    // a trailing byte with no result may still be in flight
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Covered %0d console bytes, %0d result words: %0d token bytes, %0d token ends,",
             bytes_in, words_out, ev_cnt[EV_BYTE], ev_cnt[EV_END]);
    $display("  %0d pipes, %0d instruction ends, %0d empty ends, %0d syntax errors.",
             ev_cnt[EV_PIPE], ev_cnt[EV_INSTR], ev_cnt[EV_EMPTY], ev_cnt[EV_ERROR]);
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
